[src/assert_macros.svh]
// Assertion macros shared by the RTL of the empty square search.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

[src/les_pkg.sv]
// Shared constants and types for the largest empty square search.
// Used by les_square_unit and largest_empty_square_search; no dependencies.
`default_nettype none

package les_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int SIZE_W     = 7;
    localparam int POS_W      = 6;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS = 1'b1;

    localparam logic [CFG_W-1:0] GRID_ROWS_RST = 7'd64;
    localparam logic [CFG_W-1:0] GRID_COLS_RST = 7'd64;

    // Per-cycle commands from the sequencer to the square unit.
    typedef struct packed {
        logic clear;      // start of a search: forget the previous best
        logic rd_en;      // fetch the line buffer entry of the current column
        logic calc_en;    // evaluate the current cell and write back
        logic row_start;  // first cell of a row: nothing to the right
        logic first_row;  // bottom row: nothing below
    } sq_ctrl_t;

endpackage

`default_nettype wire

[src/les_cell_store.sv]
// Grid cell memory: one bit per cell, one write port and one registered read port.
// Stand-alone; sized by the MAX_ROWS and MAX_COLS parameters of the top level.
`default_nettype none

module les_cell_store #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] wr_row,
    input  wire logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] wr_col,
    input  wire logic                                     wr_bit,
    input  wire logic                                     rd_en,
    input  wire logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] rd_row,
    input  wire logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] rd_col,
    output logic                                          rd_bit
);

    logic cell_mem [MAX_ROWS][MAX_COLS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_row][wr_col] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_bit <= cell_mem[rd_row][rd_col];
        end
    end

endmodule

`default_nettype wire

[src/les_square_unit.sv]
// Shared square-size unit: min-of-three plus one, best tracking, and the line buffer
// that holds the square sizes of the row below. Depends on les_pkg.
`default_nettype none

module les_square_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire les_pkg::sq_ctrl_t                        ctrl,
    input  wire logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] row,
    input  wire logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] col,
    input  wire logic                                     cell_free,
    output logic [$clog2(((MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1)-1:0] best_side,
    output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] best_top,
    output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] best_left
);

    localparam int MAX_SIDE = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [SW-1:0] line_mem [MAX_COLS];
    logic [SW-1:0] below_reg;
    logic [SW-1:0] right_reg;
    logic [SW-1:0] right_next;
    logic [SW-1:0] diag_reg;
    logic [SW-1:0] diag_next;
    logic [SW-1:0] best_side_reg;
    logic [SW-1:0] best_side_next;
    logic [RW-1:0] best_top_reg;
    logic [RW-1:0] best_top_next;
    logic [CW-1:0] best_left_reg;
    logic [CW-1:0] best_left_next;

    logic [SW-1:0] below;
    logic [SW-1:0] min_br;
    logic [SW-1:0] min_all;
    logic [SW-1:0] side;

    // The bottom row has no row below it, so the line buffer entry read there is replaced by zero.
    assign below   = ctrl.first_row ? '0 : below_reg;
    assign min_br  = (below < right_reg) ? below : right_reg;
    assign min_all = (min_br < diag_reg) ? min_br : diag_reg;
    assign side    = cell_free ? SW'(min_all + 1'b1) : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            below_reg <= line_mem[col];
        end
        if (ctrl.calc_en)
        begin
            line_mem[col] <= side;
        end
    end

    always_comb
    begin
        right_next     = right_reg;
        diag_next      = diag_reg;
        best_side_next = best_side_reg;
        best_top_next  = best_top_reg;
        best_left_next = best_left_reg;
        if (ctrl.clear)
        begin
            best_side_next = '0;
            best_top_next  = '0;
            best_left_next = '0;
        end
        if (ctrl.rd_en && ctrl.row_start)
        begin
            right_next = '0;
            diag_next  = '0;
        end
        if (ctrl.calc_en)
        begin
            right_next = side;
            diag_next  = below;
            // The scan runs backward, so a tie moves the winner toward the grid's start.
            if ((side != '0) && (side >= best_side_reg))
            begin
                best_side_next = side;
                best_top_next  = row;
                best_left_next = col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg     <= '0;
            diag_reg      <= '0;
            best_side_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
        end
        else
        begin
            right_reg     <= right_next;
            diag_reg      <= diag_next;
            best_side_reg <= best_side_next;
            best_top_reg  <= best_top_next;
            best_left_reg <= best_left_next;
        end
    end

    assign best_side = best_side_reg;
    assign best_top  = best_top_reg;
    assign best_left = best_left_reg;

endmodule

`default_nettype wire

[src/largest_empty_square_search.sv]
// Top level of the largest empty square search: configuration, cell loader,
// search sequencer and result register. Depends on les_pkg, les_cell_store,
// les_square_unit and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Cells stream in on the slave side one per cycle, row by row, and are stored
// in a single-port-write cell memory; tready stays high while loading. The
// cell marked with tlast ends the grid and starts the search, during which
// tready is low. The search visits every cell in use from the bottom-right
// corner back to the top-left; for each cell a read state fetches the cell
// and the row-below size from memory, then a calc state runs the shared
// min-of-three unit and writes back. The result is posted from S_DONE.
// The result waits in an output register; loading of the next grid resumes
// as soon as it is posted. A result still unclaimed when the next search ends
// holds the block until it is taken.

module largest_empty_square_search #(
    parameter int MAX_ROWS = les_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = les_pkg::MAX_COLS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [les_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [les_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [les_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] cell_free, rest zero
    input  wire logic                              s_tlast,   // last_cell
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [les_pkg::OUT_TDATA_W-1:0]        m_tdata    // [6:0] square_side,
                                                              // [12:7] best_row,
                                                              // [18:13] best_col
);

    localparam int MAX_SIDE = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [les_pkg::CFG_W-1:0] grid_rows_reg;
    logic [les_pkg::CFG_W-1:0] grid_cols_reg;

    logic [RCW-1:0] rows_c;
    logic [CCW-1:0] cols_c;
    logic [RW-1:0]  rows_m1;
    logic [CW-1:0]  cols_m1;

    logic [RCW-1:0] load_row_reg;
    logic [RCW-1:0] load_row_next;
    logic [CCW-1:0] load_col_reg;
    logic [CCW-1:0] load_col_next;
    logic [CCW-1:0] load_col_inc;

    logic [RW-1:0] scan_r_reg;
    logic [RW-1:0] scan_r_next;
    logic [CW-1:0] scan_c_reg;
    logic [CW-1:0] scan_c_next;
    logic          row_start_reg;
    logic          row_start_next;
    logic          first_row_reg;
    logic          first_row_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [les_pkg::SIZE_W-1:0] out_size_reg;
    logic [les_pkg::POS_W-1:0]  out_row_reg;
    logic [les_pkg::POS_W-1:0]  out_col_reg;
    logic                      out_load;

    logic in_xfer;
    logic wr_en;
    logic cell_bit;
    logic cell_free_q;
    les_pkg::sq_ctrl_t sq_ctrl;

    logic [SW-1:0] best_side;
    logic [RW-1:0] best_top;
    logic [CW-1:0] best_left;

    // Out-of-range sizes: zero reads as one, anything above the maximum as the maximum.
    assign rows_c = (grid_rows_reg == '0) ? RCW'(1) :
                    (32'(grid_rows_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(grid_rows_reg);
    assign cols_c = (grid_cols_reg == '0) ? CCW'(1) :
                    (32'(grid_cols_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(grid_cols_reg);
    assign rows_m1 = RW'(rows_c - 1'b1);
    assign cols_m1 = CW'(cols_c - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= les_pkg::GRID_ROWS_RST;
            grid_cols_reg <= les_pkg::GRID_COLS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                les_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                les_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == S_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign cell_bit = s_tdata[0];
    assign wr_en    = in_xfer && (load_row_reg < rows_c) && (load_col_reg < cols_c);
    assign load_col_inc = load_col_reg + 1'b1;

    // Loader: cells past the grid are dropped, and a column beyond a narrowed grid
    // only advances to the next row.
    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        if (in_xfer)
        begin
            if (s_tlast)
            begin
                load_row_next = '0;
                load_col_next = '0;
            end
            else if (wr_en)
            begin
                if (load_col_inc >= cols_c)
                begin
                    load_col_next = '0;
                    load_row_next = load_row_reg + 1'b1;
                end
                else
                begin
                    load_col_next = load_col_inc;
                end
            end
            else if (load_row_reg < rows_c)
            begin
                load_col_next = '0;
                load_row_next = load_row_reg + 1'b1;
            end
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        scan_r_next    = scan_r_reg;
        scan_c_next    = scan_c_reg;
        row_start_next = row_start_reg;
        first_row_next = first_row_reg;
        sq_ctrl        = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_xfer && s_tlast)
                begin
                    sq_ctrl.clear  = 1'b1;
                    scan_r_next    = rows_m1;
                    scan_c_next    = cols_m1;
                    row_start_next = 1'b1;
                    first_row_next = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                sq_ctrl.rd_en     = 1'b1;
                sq_ctrl.row_start = row_start_reg;
                state_next        = S_CALC;
            end
            S_CALC:
            begin
                sq_ctrl.calc_en   = 1'b1;
                sq_ctrl.first_row = first_row_reg;
                if (scan_c_reg == '0)
                begin
                    if (scan_r_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        scan_r_next    = scan_r_reg - 1'b1;
                        scan_c_next    = cols_m1;
                        row_start_next = 1'b1;
                        first_row_next = 1'b0;
                        state_next     = S_READ;
                    end
                end
                else
                begin
                    scan_c_next    = scan_c_reg - 1'b1;
                    row_start_next = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            scan_r_reg    <= '0;
            scan_c_reg    <= '0;
            row_start_reg <= 1'b0;
            first_row_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            scan_r_reg    <= scan_r_next;
            scan_c_reg    <= scan_c_next;
            row_start_reg <= row_start_next;
            first_row_reg <= first_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_size_reg <= les_pkg::SIZE_W'(best_side);
            out_row_reg  <= les_pkg::POS_W'(best_top);
            out_col_reg  <= les_pkg::POS_W'(best_left);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_col_reg, out_row_reg, out_size_reg};

    les_cell_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cell_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_row (load_row_reg[RW-1:0]),
        .wr_col (load_col_reg[CW-1:0]),
        .wr_bit (cell_bit),
        .rd_en  (sq_ctrl.rd_en),
        .rd_row (scan_r_reg),
        .rd_col (scan_c_reg),
        .rd_bit (cell_free_q)
    );

    les_square_unit #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_square_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sq_ctrl),
        .row       (scan_r_reg),
        .col       (scan_c_reg),
        .cell_free (cell_free_q),
        .best_side (best_side),
        .best_top  (best_top),
        .best_left (best_left)
    );

    `ASSERT_NEXT(a_last_starts_search, in_xfer && s_tlast,
                 state_reg == S_READ && load_row_reg == '0 && load_col_reg == '0)
    `ASSERT_NEXT(a_read_then_calc, state_reg == S_READ, state_reg == S_CALC)
    `ASSERT_NEXT(a_done_posts_result, out_load, m_tvalid && state_reg == S_LOAD)

endmodule

`default_nettype wire
